>>> rtl/sba_pkg.sv
// shared types and constants of the segment allocator
// no dependencies
package sba_pkg;

    localparam int NSEG  = 64;
    localparam int IDXW  = $clog2(NSEG);
    localparam int WORDW = 16;
    localparam int BYTEW = 19;
    localparam int DIVW  = BYTEW + 1;
    localparam int CIDXW = 2;
    localparam int CDATW = 16;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_FIT   = 3'd1;
    localparam logic [2:0] ST_ZERO     = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    localparam logic [CIDXW-1:0] REG_FIT   = 2'd0;
    localparam logic [CIDXW-1:0] REG_BPW   = 2'd1;
    localparam logic [CIDXW-1:0] REG_TOTAL = 2'd2;

    localparam logic FUNC_ALLOC = 1'b0;

    typedef struct packed {
        logic             valid;
        logic [WORDW-1:0] start;
        logic [WORDW-1:0] len;
        logic             hole;
    } t_seg;

    typedef struct packed {
        logic shift;
        logic build;
    } t_cell_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SCAN,
        S_APPLY,
        S_DONE
    } t_state;

endpackage

>>> rtl/sba_cell.sv
// one segment table cell of the shifting chain
// depends on sba_pkg
module sba_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sba_pkg::t_cell_ctl i_ctl,
    input  sba_pkg::t_seg      i_init,
    input  sba_pkg::t_seg      i_d,
    output sba_pkg::t_seg      o_q
);
    sba_pkg::t_seg r_seg;
    sba_pkg::t_seg n_seg;

    always_comb begin
        n_seg = r_seg;
        if (i_ctl.build) begin
            n_seg = i_init;
        end else if (i_ctl.shift) begin
            n_seg = i_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg.valid <= 1'b0;
        end else begin
            r_seg.valid <= n_seg.valid;
        end
        r_seg.start <= n_seg.start;
        r_seg.len   <= n_seg.len;
        r_seg.hole  <= n_seg.hole;
    end

    assign o_q = r_seg;
endmodule

>>> rtl/sba_div.sv
// bit-serial divider by the word size, one quotient bit per cycle
// depends on sba_pkg
module sba_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [sba_pkg::DIVW-1:0] i_dividend,
    input  logic [3:0]               i_divisor,
    output logic                     o_done,
    output logic [sba_pkg::DIVW-1:0] o_quot
);
    localparam int CW = $clog2(sba_pkg::DIVW + 1);

    logic                     r_busy, n_busy;
    logic [CW-1:0]            r_cnt, n_cnt;
    logic [2:0]               r_rem, n_rem;
    logic [sba_pkg::DIVW-1:0] r_q, n_q;
    logic [3:0]               r_d, n_d;
    logic [3:0]               sh;
    logic                     ge;

    always_comb begin
        sh     = {r_rem, r_q[sba_pkg::DIVW-1]};
        ge     = sh >= r_d;
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_q    = r_q;
        n_d    = r_d;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_q    = i_dividend;
            n_d    = i_divisor;
        end else if (r_busy) begin
            n_rem = ge ? 3'(sh - r_d) : sh[2:0];
            n_q   = {r_q[sba_pkg::DIVW-2:0], ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CW'(sba_pkg::DIVW - 1)) begin
                n_busy = 1'b0;
            end
        end
        o_done = !r_busy && (r_cnt == CW'(sba_pkg::DIVW));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_q   <= n_q;
        r_d   <= n_d;
    end

    assign o_quot = r_q;
endmodule

>>> rtl/segment_allocator_best_worst_fit.sv
// Segment allocator: a word is taken only while idle, and its result word is loaded into
// the output register after bit-serial division by the word size, then one rotation of
// the segment chain to search or free, and for an allocation that is applied one more
// rotation to apply it; a zero-size request skips both rotations and an allocation that
// is not applied skips the second. A result word still waiting to be taken holds off the
// load; the next word is taken in the cycle after the load.
// depends on sba_pkg, sba_cell, sba_div
module segment_allocator_best_worst_fit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_func,
    input  logic [sba_pkg::BYTEW-1:0] i_request_bytes,
    input  logic [sba_pkg::BYTEW-1:0] i_free_byte_offset,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [2:0]                o_status,
    output logic [sba_pkg::BYTEW-1:0] o_alloc_byte_offset,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [sba_pkg::CIDXW-1:0] i_cfg_index,
    input  logic [sba_pkg::CDATW-1:0] i_cfg_data
);
    localparam int N = sba_pkg::NSEG;
    localparam int IW = sba_pkg::IDXW;

    sba_pkg::t_state r_state, n_state;

    logic       r_fit;
    logic [3:0] r_bpw;
    logic [15:0] r_total;
    logic       r_ready_tbl;
    logic [IW:0] r_count, n_count;
    logic       r_func, n_func;
    logic [sba_pkg::DIVW-1:0] r_words, n_words;
    logic [IW-1:0] r_cnt, n_cnt;
    logic       r_found, n_found;
    logic [IW-1:0] r_pick, n_pick;
    logic [15:0] r_pick_len, n_pick_len;
    logic [15:0] r_pick_start, n_pick_start;
    logic       r_hit, n_hit;
    logic       r_split, n_split;
    sba_pkg::t_seg r_carry, n_carry;
    logic       r_carry_v, n_carry_v;
    logic [2:0] r_st, n_st;
    logic       r_out_valid;
    logic [2:0] r_status;
    logic [sba_pkg::BYTEW-1:0] r_ofs;

    logic [3:0] bpw;
    logic       accept;
    logic       build;
    logic       div_done;
    logic [sba_pkg::DIVW-1:0] div_q;
    logic [sba_pkg::DIVW-1:0] dividend;
    logic       load_out;
    logic       fits;
    logic       better;
    logic [19:0] prod;

    sba_pkg::t_cell_ctl ctl;
    sba_pkg::t_seg      push;
    sba_pkg::t_seg      head;
    sba_pkg::t_seg      q [N];
    sba_pkg::t_seg      seg0;

    assign bpw = (r_bpw == 4'd0) ? 4'd1 : ((r_bpw > 4'd8) ? 4'd8 : r_bpw);
    assign o_in_ready = (r_state == sba_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept = i_in_valid && o_in_ready;
    assign build = accept && (i_func == sba_pkg::FUNC_ALLOC) && !r_ready_tbl;
    assign dividend = (i_func == sba_pkg::FUNC_ALLOC)
                    ? ({1'b0, i_request_bytes} + sba_pkg::DIVW'(bpw) - sba_pkg::DIVW'(1))
                    : {1'b0, i_free_byte_offset};
    assign seg0 = '{valid: 1'b1, start: 16'd0, len: r_total, hole: 1'b1};
    assign head = q[0];
    assign prod = r_pick_start * bpw;

    sba_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept),
        .i_dividend (dividend),
        .i_divisor  (bpw),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    assign ctl.shift = (r_state == sba_pkg::S_SCAN) || (r_state == sba_pkg::S_APPLY);
    assign ctl.build = build;

    for (genvar k = 0; k < N; k++) begin : g_cell
        sba_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_init  ((k == 0) ? seg0 : sba_pkg::t_seg'('0)),
            .i_d     ((k == N - 1) ? push : q[(k + 1) % N]),
            .o_q     (q[k])
        );
    end

    assign fits = head.valid && head.hole && ({4'd0, head.len} >= r_words);
    assign better = r_fit ? (head.len > r_pick_len) : (head.len < r_pick_len);
    assign load_out = (r_state == sba_pkg::S_DONE) && (!r_out_valid || i_out_ready);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sba_pkg::S_IDLE: begin
                if (accept) n_state = sba_pkg::S_DIV;
            end
            sba_pkg::S_DIV: begin
                if (div_done) begin
                    if (r_func == sba_pkg::FUNC_ALLOC && div_q == '0) begin
                        n_state = sba_pkg::S_DONE;
                    end else begin
                        n_state = sba_pkg::S_SCAN;
                    end
                end
            end
            sba_pkg::S_SCAN: begin
                if (r_cnt == IW'(N - 1)) begin
                    if (r_func != sba_pkg::FUNC_ALLOC) begin
                        n_state = sba_pkg::S_DONE;
                    end else if (n_found
                                 && (n_pick_len == r_words[15:0]
                                     || r_count < (IW + 1)'(N))) begin
                        n_state = sba_pkg::S_APPLY;
                    end else begin
                        n_state = sba_pkg::S_DONE;
                    end
                end
            end
            sba_pkg::S_APPLY: begin
                if (r_cnt == IW'(N - 1)) n_state = sba_pkg::S_DONE;
            end
            sba_pkg::S_DONE: begin
                if (load_out) n_state = sba_pkg::S_IDLE;
            end
            default: n_state = sba_pkg::S_IDLE;
        endcase
    end

    // datapath and chain feed
    always_comb begin
        n_count      = r_count;
        n_func       = r_func;
        n_words      = r_words;
        n_cnt        = r_cnt;
        n_found      = r_found;
        n_pick       = r_pick;
        n_pick_len   = r_pick_len;
        n_pick_start = r_pick_start;
        n_hit        = r_hit;
        n_split      = r_split;
        n_carry      = r_carry;
        n_carry_v    = r_carry_v;
        n_st         = r_st;
        push         = head;
        case (r_state)
            sba_pkg::S_IDLE: begin
                if (accept) begin
                    n_func    = i_func;
                    n_found   = 1'b0;
                    n_hit     = 1'b0;
                    n_carry_v = 1'b0;
                    n_cnt     = '0;
                    if (build) n_count = (IW + 1)'(1);
                end
            end
            sba_pkg::S_DIV: begin
                n_words = div_q;
                if (div_done && r_func == sba_pkg::FUNC_ALLOC && div_q == '0) begin
                    n_st = sba_pkg::ST_ZERO;
                end
            end
            sba_pkg::S_SCAN: begin
                n_cnt = r_cnt + 1'b1;
                if (r_func != sba_pkg::FUNC_ALLOC) begin
                    if (head.valid && {4'd0, head.start} == r_words) begin
                        push.hole = 1'b1;
                        n_hit = 1'b1;
                    end
                end else if (fits && (!r_found || better)) begin
                    n_found      = 1'b1;
                    n_pick       = r_cnt;
                    n_pick_len   = head.len;
                    n_pick_start = head.start;
                end
                if (r_cnt == IW'(N - 1)) begin
                    if (r_func != sba_pkg::FUNC_ALLOC) begin
                        n_st = n_hit ? sba_pkg::ST_OK : sba_pkg::ST_NOT_FOUND;
                    end else if (!n_found) begin
                        n_st = sba_pkg::ST_NO_FIT;
                    end else if (n_pick_len == r_words[15:0]) begin
                        n_st    = sba_pkg::ST_OK;
                        n_split = 1'b0;
                    end else if (r_count < (IW + 1)'(N)) begin
                        n_st    = sba_pkg::ST_OK;
                        n_split = 1'b1;
                        n_count = r_count + 1'b1;
                    end else begin
                        n_st = sba_pkg::ST_FULL;
                    end
                end
            end
            sba_pkg::S_APPLY: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == r_pick) begin
                    push.hole = 1'b0;
                    if (r_split) begin
                        push.len      = r_words[15:0];
                        n_carry.valid = 1'b1;
                        n_carry.start = head.start + r_words[15:0];
                        n_carry.len   = head.len - r_words[15:0];
                        n_carry.hole  = 1'b1;
                        n_carry_v     = 1'b1;
                    end
                end else if (r_carry_v) begin
                    push = r_carry;
                    if (head.valid) begin
                        n_carry = head;
                    end else begin
                        n_carry_v = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sba_pkg::S_IDLE;
            r_fit       <= 1'b0;
            r_bpw       <= 4'd8;
            r_total     <= 16'hFFFF;
            r_ready_tbl <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (build) r_ready_tbl <= 1'b1;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    sba_pkg::REG_FIT:   r_fit   <= i_cfg_data[0];
                    sba_pkg::REG_BPW:   r_bpw   <= i_cfg_data[3:0];
                    sba_pkg::REG_TOTAL: r_total <= i_cfg_data;
                    default: ;
                endcase
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        r_func       <= n_func;
        r_words      <= n_words;
        r_cnt        <= n_cnt;
        r_found      <= n_found;
        r_pick       <= n_pick;
        r_pick_len   <= n_pick_len;
        r_pick_start <= n_pick_start;
        r_hit        <= n_hit;
        r_split      <= n_split;
        r_carry      <= n_carry;
        r_carry_v    <= n_carry_v;
        r_st         <= n_st;
        if (load_out) begin
            r_status <= r_st;
            r_ofs    <= (r_func == sba_pkg::FUNC_ALLOC && r_st == sba_pkg::ST_OK)
                      ? prod[sba_pkg::BYTEW-1:0] : '0;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_status            = r_status;
    assign o_alloc_byte_offset = r_ofs;
endmodule
